@@ rtl/pfba_pkg.sv @@
package pfba_pkg;

  // Widths fixed by the item and result fields
  localparam int OP_W     = 3;
  localparam int PAGE_W   = 12;
  localparam int CNT_W    = 13;
  localparam int STATUS_W = 2;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam op_t OP_ALLOC   = 3'd0;
  localparam op_t OP_FREE    = 3'd1;
  localparam op_t OP_RESERVE = 3'd2;
  localparam op_t OP_RELEASE = 3'd3;
  localparam op_t OP_REQUEST = 3'd4;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_NO_FREE = 2'd1;
  localparam status_t ST_CLIPPED = 2'd2;

  localparam logic [CNT_W-1:0] TOTAL_RESET = 13'd4096;

endpackage

@@ rtl/pfba_ram.sv @@
module pfba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/page_frame_bitmap_allocator_core.sv @@
// Bitmap page-frame allocator. One busy bit per frame lives in a word-wide
// RAM (WORD_BITS frames per word). After reset the block sweeps the RAM to
// zero, one word per cycle, holding busy high until the last word is cleared.
// An item is taken when start is high and busy is low. A run op touches
// words first..last of its clipped range, and a request scans words from
// zero up to the managed total until it finds a clear bit; both stream
// through the RAM read port at one word per cycle, with each modified word
// written back as its read data arrives. An item passes through two divide
// states, the scan and a done state; one touching no word goes straight to
// the done state. The result appears for exactly one cycle with done high,
// in the first cycle that busy is low again; the receiver cannot stall it.
// total_pages may be written only while busy is low and no result is pending.
module page_frame_bitmap_allocator_core #(
  parameter int MAX_FRAMES = 4096,
  parameter int WORD_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pfba_pkg::CNT_W-1:0]    cfg_data,
  input  logic                          start,
  output logic                          busy,
  input  pfba_pkg::op_t                 op,
  input  logic [pfba_pkg::PAGE_W-1:0]   start_page,
  input  logic [pfba_pkg::CNT_W-1:0]    page_count,
  output logic                          done,
  output logic [pfba_pkg::PAGE_W-1:0]   page_found,
  output pfba_pkg::status_t             status,
  output logic [pfba_pkg::CNT_W-1:0]    free_pages,
  output logic [pfba_pkg::CNT_W-1:0]    used_pages,
  output logic [pfba_pkg::CNT_W-1:0]    reserved_pages
);

  localparam int PW        = pfba_pkg::CNT_W;
  localparam int EW        = PW + 1;
  localparam int NUM_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int CW        = $clog2(MAX_FRAMES + 1);
  localparam int SW        = ((CW > PW) ? CW : PW) + 1;
  localparam int OW        = $clog2(WORD_BITS + 1);
  localparam int IW        = $clog2(WORD_BITS);
  localparam int DIV_K     = 16;
  localparam int RECIP     = (1 << DIV_K) / WORD_BITS;
  localparam int RW        = $clog2(RECIP + 1);
  localparam int MW        = PW + RW;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIV1  = 3'd2;
  localparam logic [2:0] ST_DIV2  = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]              state;
  logic [AW-1:0]           clr_addr;
  logic [PW-1:0]           total_pages;
  logic [CW-1:0]           used_cnt;
  logic [CW-1:0]           res_cnt;

  pfba_pkg::op_t           cur_op;
  pfba_pkg::status_t       item_status;
  logic [PW-1:0]           n_touch;
  logic [PW-1:0]           lo_src;
  logic [PW-1:0]           hi_src;
  logic [PW-1:0]           q_lo;
  logic [PW-1:0]           q_hi;
  logic [AW-1:0]           first_word;
  logic [AW-1:0]           last_word;
  logic [OW-1:0]           lo_off;
  logic [OW-1:0]           hi_off;
  logic [AW-1:0]           rd_addr;
  logic [AW-1:0]           rd_word;
  logic                    issue;
  logic                    rd_pend;
  logic                    hit;
  logic [AW-1:0]           hit_word;
  logic [IW-1:0]           hit_idx;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [WORD_BITS-1:0]    ram_wdata;
  logic [WORD_BITS-1:0]    ram_rdata;

  logic [PW-1:0]           total_eff;
  logic [EW-1:0]           end_page;
  logic                    clipped;
  logic [EW-1:0]           stop_page;
  logic                    run_live;

  logic [MW-1:0]           prod_lo;
  logic [MW-1:0]           prod_hi;
  logic [PW-1:0]           r_lo_raw;
  logic [PW-1:0]           r_hi_raw;
  logic                    fix_lo;
  logic                    fix_hi;
  logic [PW-1:0]           r_lo;
  logic [PW-1:0]           r_hi;

  logic [OW-1:0]           lo_bound;
  logic [OW-1:0]           hi_bound;
  logic [WORD_BITS-1:0]    word_mask;
  logic [WORD_BITS-1:0]    cand;
  logic [WORD_BITS-1:0]    lsb;
  logic [IW-1:0]           lsb_idx;
  logic                    hit_any;
  logic                    set_bits;

  logic [SW-1:0]           used_sum;
  logic [SW-1:0]           used_dec;
  logic [SW-1:0]           res_sum;
  logic [SW-1:0]           res_dec;
  logic [CW-1:0]           used_new;
  logic [CW-1:0]           res_new;
  logic [SW:0]             taken;
  logic [PW-1:0]           free_new;
  logic [PW-1:0]           found_calc;

  function automatic logic [WORD_BITS-1:0] below_mask(input logic [OW-1:0] n);
    logic [WORD_BITS-1:0] m;
    for (int b = 0; b < WORD_BITS; b++) begin
      m[b] = (OW'(b) < n);
    end
    return m;
  endfunction

  pfba_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(NUM_WORDS)
  ) u_bitmap (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  assign busy = (state != ST_IDLE);

  // Item setup: clip the run against the managed total
  always_comb begin
    total_eff = (SW'(total_pages) > SW'(MAX_FRAMES)) ? PW'(MAX_FRAMES) : total_pages;
    end_page  = EW'(start_page) + EW'(page_count);
    clipped   = (page_count != '0) && (end_page > EW'(total_eff));
    stop_page = clipped ? EW'(total_eff) : end_page;
    run_live  = stop_page > EW'(start_page);
  end

  // Word index and bit offset of both range ends, by reciprocal multiply
  always_comb begin
    prod_lo  = MW'(lo_src) * MW'(RECIP);
    prod_hi  = MW'(hi_src) * MW'(RECIP);
    r_lo_raw = lo_src - PW'(q_lo * PW'(WORD_BITS));
    r_hi_raw = hi_src - PW'(q_hi * PW'(WORD_BITS));
    fix_lo   = r_lo_raw >= PW'(WORD_BITS);
    fix_hi   = r_hi_raw >= PW'(WORD_BITS);
    r_lo     = fix_lo ? (r_lo_raw - PW'(WORD_BITS)) : r_lo_raw;
    r_hi     = fix_hi ? (r_hi_raw - PW'(WORD_BITS)) : r_hi_raw;
  end

  // Per-word mask, lowest clear frame, and write-back data
  always_comb begin
    lo_bound  = (rd_word == first_word) ? lo_off : '0;
    hi_bound  = (rd_word == last_word) ? hi_off : OW'(WORD_BITS);
    word_mask = below_mask(hi_bound) & ~below_mask(lo_bound);
    cand      = ~ram_rdata & word_mask;
    hit_any   = |cand;
    lsb       = cand & (~cand + WORD_BITS'(1));
    lsb_idx   = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      lsb_idx = lsb_idx | (lsb[b] ? IW'(b) : '0);
    end
    set_bits  = (cur_op == pfba_pkg::OP_ALLOC) || (cur_op == pfba_pkg::OP_RESERVE);

    ram_we    = 1'b0;
    ram_waddr = rd_word;
    ram_wdata = ram_rdata;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      ST_SCAN: begin
        if (rd_pend) begin
          if (cur_op == pfba_pkg::OP_REQUEST) begin
            ram_we    = hit_any;
            ram_wdata = ram_rdata | lsb;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = set_bits ? (ram_rdata | word_mask) : (ram_rdata & ~word_mask);
          end
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Saturating counters and result values
  always_comb begin
    used_sum = SW'(used_cnt) + SW'(n_touch);
    used_dec = (SW'(used_cnt) > SW'(n_touch)) ? (SW'(used_cnt) - SW'(n_touch)) : '0;
    res_sum  = SW'(res_cnt) + SW'(n_touch);
    res_dec  = (SW'(res_cnt) > SW'(n_touch)) ? (SW'(res_cnt) - SW'(n_touch)) : '0;
    used_new = used_cnt;
    res_new  = res_cnt;
    case (cur_op)
      pfba_pkg::OP_ALLOC,
      pfba_pkg::OP_REQUEST: begin
        used_new = (used_sum > SW'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : CW'(used_sum);
      end
      pfba_pkg::OP_FREE: begin
        used_new = CW'(used_dec);
      end
      pfba_pkg::OP_RESERVE: begin
        res_new = (res_sum > SW'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : CW'(res_sum);
      end
      pfba_pkg::OP_RELEASE: begin
        res_new = CW'(res_dec);
      end
      default: begin
        used_new = used_cnt;
      end
    endcase
    taken      = (SW + 1)'(used_new) + (SW + 1)'(res_new);
    free_new   = (taken >= (SW + 1)'(total_eff)) ? '0
                 : PW'((SW + 1)'(total_eff) - taken);
    found_calc = PW'(hit_word) * PW'(WORD_BITS) + PW'(hit_idx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      total_pages <= pfba_pkg::TOTAL_RESET;
      used_cnt    <= '0;
      res_cnt     <= '0;
      done        <= 1'b0;
      issue       <= 1'b0;
      rd_pend     <= 1'b0;
      rd_addr     <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        total_pages <= cfg_data;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(NUM_WORDS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            cur_op  <= op;
            hit     <= 1'b0;
            n_touch <= '0;
            case (op)
              pfba_pkg::OP_ALLOC,
              pfba_pkg::OP_FREE,
              pfba_pkg::OP_RESERVE,
              pfba_pkg::OP_RELEASE: begin
                item_status <= clipped ? pfba_pkg::ST_CLIPPED : pfba_pkg::ST_OK;
                lo_src      <= PW'(start_page);
                hi_src      <= PW'(stop_page - EW'(1));
                if (run_live) begin
                  n_touch <= PW'(stop_page - EW'(start_page));
                  state   <= ST_DIV1;
                end else begin
                  state <= ST_DONE;
                end
              end
              pfba_pkg::OP_REQUEST: begin
                item_status <= pfba_pkg::ST_NO_FREE;
                lo_src      <= '0;
                hi_src      <= total_eff - PW'(1);
                state       <= (total_eff != '0) ? ST_DIV1 : ST_DONE;
              end
              default: begin
                item_status <= pfba_pkg::ST_OK;
                state       <= ST_DONE;
              end
            endcase
          end
        end
        ST_DIV1: begin
          q_lo  <= PW'(prod_lo >> DIV_K);
          q_hi  <= PW'(prod_hi >> DIV_K);
          state <= ST_DIV2;
        end
        ST_DIV2: begin
          first_word <= AW'(q_lo + PW'(fix_lo));
          last_word  <= AW'(q_hi + PW'(fix_hi));
          lo_off     <= OW'(r_lo);
          hi_off     <= OW'(r_hi) + OW'(1);
          rd_addr    <= AW'(q_lo + PW'(fix_lo));
          issue      <= 1'b1;
          rd_pend    <= 1'b0;
          state      <= ST_SCAN;
        end
        ST_SCAN: begin
          // read stream: one word address per cycle, data in the cycle after
          rd_pend <= issue;
          if (issue) begin
            rd_word <= rd_addr;
            if (rd_addr == last_word) begin
              issue <= 1'b0;
            end else begin
              rd_addr <= rd_addr + AW'(1);
            end
          end
          if (rd_pend) begin
            if (cur_op == pfba_pkg::OP_REQUEST && hit_any) begin
              hit         <= 1'b1;
              hit_word    <= rd_word;
              hit_idx     <= lsb_idx;
              n_touch     <= PW'(1);
              item_status <= pfba_pkg::ST_OK;
              issue       <= 1'b0;
              rd_pend     <= 1'b0;
              state       <= ST_DONE;
            end else if (rd_word == last_word) begin
              issue   <= 1'b0;
              rd_pend <= 1'b0;
              state   <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          used_cnt       <= used_new;
          res_cnt        <= res_new;
          page_found     <= hit ? found_calc[pfba_pkg::PAGE_W-1:0] : '0;
          status         <= item_status;
          free_pages     <= free_new;
          used_pages     <= PW'(used_new);
          reserved_pages <= PW'(res_new);
          done           <= 1'b1;
          state          <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_DONE))
    else $error("result strobe without a finished item");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not start");

  a_bitmap_write_phase: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_CLEAR || state == ST_SCAN))
    else $error("bitmap written outside clear or scan");

  a_counters_bounded: assert property (@(posedge clk) disable iff (rst)
    (SW'(used_cnt) <= SW'(MAX_FRAMES)) && (SW'(res_cnt) <= SW'(MAX_FRAMES)))
    else $error("page counter above frame count");

  a_found_only_ok: assert property (@(posedge clk) disable iff (rst)
    (done && status != pfba_pkg::ST_OK) |-> (page_found == '0))
    else $error("frame index reported on failed item");

endmodule

@@ tb/sv/page_frame_bitmap_allocator_core_checker.sv @@
module page_frame_bitmap_allocator_core_checker #(
  parameter int MAX_FRAMES = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pfba_pkg::CNT_W-1:0]    cfg_data,
  input  logic                          start,
  input  logic                          busy,
  input  pfba_pkg::op_t                 op,
  input  logic [pfba_pkg::PAGE_W-1:0]   start_page,
  input  logic [pfba_pkg::CNT_W-1:0]    page_count,
  input  logic                          done,
  input  logic [pfba_pkg::PAGE_W-1:0]   page_found,
  input  pfba_pkg::status_t             status,
  input  logic [pfba_pkg::CNT_W-1:0]    free_pages,
  input  logic [pfba_pkg::CNT_W-1:0]    used_pages,
  input  logic [pfba_pkg::CNT_W-1:0]    reserved_pages,
  output int                            errors,
  output int                            outstanding,
  output int                            results_seen,
  output int                            no_free_seen,
  output int                            clipped_seen
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [pfba_pkg::PAGE_W-1:0] found;
    pfba_pkg::status_t           st;
    logic [pfba_pkg::CNT_W-1:0]  free_cnt;
    logic [pfba_pkg::CNT_W-1:0]  used_cnt;
    logic [pfba_pkg::CNT_W-1:0]  resv_cnt;
  } frame_result_t;

  logic [MAX_FRAMES-1:0]        frame_map;
  logic [pfba_pkg::CNT_W-1:0]   managed_total;
  int unsigned                  used_frames;
  int unsigned                  resv_frames;
  frame_result_t                expected_results[$];

  initial begin
    errors       = 0;
    outstanding  = 0;
    results_seen = 0;
    no_free_seen = 0;
    clipped_seen = 0;
  end

  function automatic int unsigned count_up(int unsigned c);
    return (c >= MAX_FRAMES) ? c : c + 1;
  endfunction

  function automatic int unsigned count_down(int unsigned c);
    return (c == 0) ? c : c - 1;
  endfunction

  // Updates the bitmap and counters for one item, returns the result it yields
  function automatic frame_result_t apply_frame_op(pfba_pkg::op_t code,
                                                   logic [pfba_pkg::PAGE_W-1:0] sp,
                                                   logic [pfba_pkg::CNT_W-1:0] cnt);
    int unsigned   lim;
    int unsigned   last;
    int unsigned   p;
    int unsigned   taken;
    frame_result_t r;
    lim = (32'(managed_total) > MAX_FRAMES) ? MAX_FRAMES : 32'(managed_total);
    r = '0;
    r.st = pfba_pkg::ST_OK;
    if (code <= pfba_pkg::OP_RELEASE) begin
      last = 32'(sp) + 32'(cnt);
      if (cnt != 0 && last > lim) begin
        r.st = pfba_pkg::ST_CLIPPED;
        last = lim;
      end
      for (p = 32'(sp); p < last; p++) begin
        case (code)
          pfba_pkg::OP_ALLOC: begin
            frame_map[p] = 1'b1;
            used_frames = count_up(used_frames);
          end
          pfba_pkg::OP_FREE: begin
            frame_map[p] = 1'b0;
            used_frames = count_down(used_frames);
          end
          pfba_pkg::OP_RESERVE: begin
            frame_map[p] = 1'b1;
            resv_frames = count_up(resv_frames);
          end
          default: begin
            frame_map[p] = 1'b0;
            resv_frames = count_down(resv_frames);
          end
        endcase
      end
    end else if (code == pfba_pkg::OP_REQUEST) begin
      r.st = pfba_pkg::ST_NO_FREE;
      for (p = 0; p < lim; p++) begin
        if (!frame_map[p]) begin
          frame_map[p] = 1'b1;
          used_frames = count_up(used_frames);
          r.found = pfba_pkg::PAGE_W'(p);
          r.st = pfba_pkg::ST_OK;
          break;
        end
      end
    end
    taken = used_frames + resv_frames;
    r.free_cnt = (taken >= lim) ? '0 : pfba_pkg::CNT_W'(lim - taken);
    r.used_cnt = pfba_pkg::CNT_W'(used_frames);
    r.resv_cnt = pfba_pkg::CNT_W'(resv_frames);
    return r;
  endfunction

  function automatic void check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
    end
  endfunction

  always @(posedge clk) begin
    frame_result_t want;
    if (rst) begin
      frame_map = '0;
      used_frames = 0;
      resv_frames = 0;
      managed_total = pfba_pkg::TOTAL_RESET;
      expected_results.delete();
    end else begin
      if (cfg_we)
        managed_total = cfg_data;
      // compare before pushing so a result never meets its own item
      if (done) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected result, expected none, actual page %0d status %0d",
                   $time, page_found, status);
        end else begin
          want = expected_results.pop_front();
          results_seen++;
          if (want.st == pfba_pkg::ST_NO_FREE)
            no_free_seen++;
          if (want.st == pfba_pkg::ST_CLIPPED)
            clipped_seen++;
          check_field("page_found", 32'(want.found), 32'(page_found));
          check_field("status", 32'(want.st), 32'(status));
          check_field("free_pages", 32'(want.free_cnt), 32'(free_pages));
          check_field("used_pages", 32'(want.used_cnt), 32'(used_pages));
          check_field("reserved_pages", 32'(want.resv_cnt), 32'(reserved_pages));
        end
      end
      if (start && !busy)
        expected_results.push_back(apply_frame_op(op, start_page, page_count));
    end
    outstanding <= expected_results.size();
  end

  final begin
  end

endmodule

@@ tb/sv/page_frame_bitmap_allocator_core_tb.sv @@
module page_frame_bitmap_allocator_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_FRAMES      = 4096;
  localparam int PHASES          = 9;
  localparam int ITEMS_PER_PHASE = 56;
  localparam int DRAIN_CYCLES    = 100;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [pfba_pkg::CNT_W-1:0]    cfg_data = '0;
  logic                          start = 1'b0;
  pfba_pkg::op_t                 op = pfba_pkg::OP_ALLOC;
  logic [pfba_pkg::PAGE_W-1:0]   start_page = '0;
  logic [pfba_pkg::CNT_W-1:0]    page_count = '0;
  logic                          busy;
  logic                          done;
  logic [pfba_pkg::PAGE_W-1:0]   page_found;
  pfba_pkg::status_t             status;
  logic [pfba_pkg::CNT_W-1:0]    free_pages;
  logic [pfba_pkg::CNT_W-1:0]    used_pages;
  logic [pfba_pkg::CNT_W-1:0]    reserved_pages;

  int errors;
  int outstanding;
  int results_seen;
  int no_free_seen;
  int clipped_seen;
  int items_sent = 0;
  int settings_used = 0;

  always #2 clk = ~clk;

  page_frame_bitmap_allocator_core #(
    .MAX_FRAMES(MAX_FRAMES),
    .WORD_BITS(64)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .start(start),
    .busy(busy),
    .op(op),
    .start_page(start_page),
    .page_count(page_count),
    .done(done),
    .page_found(page_found),
    .status(status),
    .free_pages(free_pages),
    .used_pages(used_pages),
    .reserved_pages(reserved_pages)
  );

  page_frame_bitmap_allocator_core_checker #(
    .MAX_FRAMES(MAX_FRAMES)
  ) frame_checker (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .start(start),
    .busy(busy),
    .op(op),
    .start_page(start_page),
    .page_count(page_count),
    .done(done),
    .page_found(page_found),
    .status(status),
    .free_pages(free_pages),
    .used_pages(used_pages),
    .reserved_pages(reserved_pages),
    .errors(errors),
    .outstanding(outstanding),
    .results_seen(results_seen),
    .no_free_seen(no_free_seen),
    .clipped_seen(clipped_seen)
  );

  // Holds start high until the item is taken; start stays high afterwards
  task automatic push_item(pfba_pkg::op_t code, logic [pfba_pkg::PAGE_W-1:0] sp,
                           logic [pfba_pkg::CNT_W-1:0] cnt);
    start <= 1'b1;
    op <= code;
    start_page <= sp;
    page_count <= cnt;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  function automatic int draw_gap();
    int r;
    r = $urandom_range(99);
    if (r < 45)
      return 0;
    else if (r < 80)
      return $urandom_range(1, 3);
    else if (r < 95)
      return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  task automatic rest_sender(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drops start right after an acceptance and waits for every result
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 || busy)
      @(posedge clk);
  endtask

  task automatic write_total(logic [pfba_pkg::CNT_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic random_item(int tot);
    int            lim;
    int            r;
    pfba_pkg::op_t code;
    logic [11:0]   sp;
    logic [12:0]   cnt;
    lim = (tot > MAX_FRAMES) ? MAX_FRAMES : tot;
    r = $urandom_range(99);
    if (r < 4)
      code = pfba_pkg::op_t'($urandom_range(5, 7));
    else if (r < 30)
      code = pfba_pkg::OP_REQUEST;
    else
      code = pfba_pkg::op_t'($urandom_range(pfba_pkg::OP_ALLOC, pfba_pkg::OP_RELEASE));
    r = $urandom_range(99);
    if (lim == 0 || r >= 85)
      sp = 12'($urandom_range(0, 4095));
    else if (r < 70)
      sp = 12'($urandom_range(0, lim - 1));
    else
      sp = (lim > 8) ? 12'($urandom_range(lim - 8, lim - 1))
                     : 12'($urandom_range(0, lim - 1));
    r = $urandom_range(99);
    if (r < 60)
      cnt = 13'($urandom_range(1, 8));
    else if (r < 80)
      cnt = 13'($urandom_range(9, 200));
    else if (r < 88)
      cnt = '0;
    else if (r < 95)
      cnt = 13'($urandom_range(201, 4096));
    else
      cnt = 13'($urandom_range(0, 8191));
    push_item(code, sp, cnt);
  endtask

  initial begin
    int phase_totals[PHASES] = '{37, 1, 4096, 0, 65, 8191, 300, 4095, 0};
    int tot;
    bit no_gaps;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: default total, counter limits, clipping, empty runs, unknown ops
    push_item(pfba_pkg::OP_REQUEST, 12'd0, 13'd0);
    rest_sender(draw_gap());
    push_item(pfba_pkg::OP_ALLOC, 12'd0, 13'd0);
    push_item(pfba_pkg::OP_ALLOC, 12'd4095, 13'd1);
    push_item(pfba_pkg::OP_ALLOC, 12'd4095, 13'd2);
    rest_sender(draw_gap());
    push_item(pfba_pkg::OP_REQUEST, 12'hfff, 13'h1fff);
    push_item(pfba_pkg::OP_FREE, 12'd0, 13'd4096);
    push_item(pfba_pkg::OP_RESERVE, 12'd0, 13'd4096);
    rest_sender(draw_gap());
    push_item(pfba_pkg::OP_RESERVE, 12'd10, 13'd5);
    push_item(pfba_pkg::OP_REQUEST, 12'd0, 13'd1);
    push_item(pfba_pkg::OP_RELEASE, 12'd0, 13'd8191);
    push_item(pfba_pkg::op_t'(5), 12'd3, 13'd3);
    push_item(pfba_pkg::op_t'(6), 12'hfff, 13'h1fff);
    push_item(pfba_pkg::op_t'(7), 12'd0, 13'd0);
    push_item(pfba_pkg::OP_ALLOC, 12'd0, 13'd4096);
    rest_sender(draw_gap());
    push_item(pfba_pkg::OP_FREE, 12'd100, 13'd50);
    push_item(pfba_pkg::OP_REQUEST, 12'd0, 13'd0);
    settle();
    // no managed frames at all
    write_total(13'd0);
    push_item(pfba_pkg::OP_REQUEST, 12'd0, 13'd0);
    push_item(pfba_pkg::OP_ALLOC, 12'd0, 13'd1);
    push_item(pfba_pkg::OP_ALLOC, 12'd7, 13'd0);
    settle();
    // total above the frame count saturates
    write_total(13'h1fff);
    push_item(pfba_pkg::OP_REQUEST, 12'd0, 13'd0);
    push_item(pfba_pkg::OP_FREE, 12'd0, 13'd8191);
    push_item(pfba_pkg::OP_RELEASE, 12'd0, 13'd4096);
    settle();

    for (int k = 0; k < PHASES; k++) begin
      tot = (k == PHASES - 1) ? $urandom_range(1, 4096) : phase_totals[k];
      write_total(pfba_pkg::CNT_W'(tot));
      no_gaps = ($urandom_range(2) == 0);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        random_item(tot);
        if (i == ITEMS_PER_PHASE - 1)
          settle();
        else if ($urandom_range(49) == 0)
          settle();
        else if (!no_gaps)
          rest_sender(draw_gap());
      end
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d items sent, %0d results checked across %0d total_pages settings",
             items_sent, results_seen, settings_used);
    $display("%0d requests found no free frame, %0d runs were clipped",
             no_free_seen, clipped_seen);
    if (errors == 0)
      $display("PASS page_frame_bitmap_allocator_core");
    else
      $display("FAIL page_frame_bitmap_allocator_core");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAIL page_frame_bitmap_allocator_core");
    $finish;
  end

endmodule
